@@ rtl/core/mtb_pkg.sv @@
// mtb_pkg: shared constants, command codes and control/status structs
// for the multi timer bank. No dependencies.
`default_nettype none

package mtb_pkg;

  // bank size and derived widths
  localparam int SLOTS     = 8;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_FIRES = 8;
  localparam int CNT_W     = $clog2(MAX_FIRES + 1);

  // field widths
  localparam int CMD_W     = 3;
  localparam int SLOTF_W   = 3;
  localparam int MS_W      = 32;
  localparam int TIME_W    = 64;

  // stream packing
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic              load;      // latch the input transfer
    logic              exec;      // apply a slot command
    logic              tick_inc;  // advance the millisecond counter
    logic              fire;      // commit a fire at scan_idx
    logic              flush;     // push the held fire as the last one
    logic [SLOT_W-1:0] scan_idx;
  } mtb_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic expired;
    logic pend_v;
    logic out_free;
  } mtb_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mtb_ctrl.sv @@
// mtb_ctrl: command sequencer and slot scan controller of the timer bank.
// Depends on mtb_pkg.
`default_nettype none

module mtb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  mtb_pkg::mtb_stat_t      stat_i,
  output mtb_pkg::mtb_ctl_t       ctl_o
);
  import mtb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // next state and datapath commands
  always_comb begin
    logic fire_ok;
    fire_ok   = 1'b0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ctl_o          = '0;
    ctl_o.scan_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl_o.load = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_tick) begin
          ctl_o.tick_inc = 1'b1;
          idx_nxt        = '0;
          cnt_nxt        = '0;
          state_nxt      = ST_SCAN;
        end else begin
          ctl_o.exec = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // a fire waits only when both the held fire and the output are occupied
        fire_ok = stat_i.expired && (!stat_i.pend_v || stat_i.out_free);
        if (!stat_i.expired || fire_ok) begin
          ctl_o.fire = fire_ok;
          idx_nxt    = SLOT_W'(idx_r + 1'b1);
          cnt_nxt    = CNT_W'(cnt_r + CNT_W'(fire_ok));
          if (idx_r == SLOT_W'(SLOTS - 1) ||
              (fire_ok && cnt_r == CNT_W'(MAX_FIRES - 1))) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (stat_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mtb_dpath.sv @@
// mtb_dpath: time counter, slot storage, shared 64-bit adder and the
// fire result registers of the timer bank. Depends on mtb_pkg.
`default_nettype none

module mtb_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  mtb_pkg::mtb_ctl_t                ctl_i,
  output mtb_pkg::mtb_stat_t               stat_o,
  input  wire logic [mtb_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [mtb_pkg::SLOTF_W-1:0] slot_i,
  input  wire logic [mtb_pkg::MS_W-1:0]    timeout_i,
  input  wire logic [mtb_pkg::MS_W-1:0]    period_i,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mtb_pkg::SLOTF_W-1:0]      fired_slot,
  output logic                             last_fired
);
  import mtb_pkg::*;

  // latched command
  logic [CMD_W-1:0]   cmd_r;
  logic [SLOTF_W-1:0] slot_r;
  logic [MS_W-1:0]    tmo_r;
  logic [MS_W-1:0]    per_r;

  // time and slot storage
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  expiry_r  [SLOTS];
  logic [MS_W-1:0]    stmo_r    [SLOTS];
  logic [MS_W-1:0]    sper_r    [SLOTS];
  logic [SLOTS-1:0]   in_use_r;
  logic [SLOTS-1:0]   held_r;

  // held fire and output register
  logic               pend_v_r;
  logic [SLOTF_W-1:0] pend_slot_r;
  logic               out_v_r;
  logic [SLOTF_W-1:0] out_slot_r;
  logic               out_last_r;

  logic [SLOT_W-1:0]  addr;
  logic               slot_ok;
  logic [TIME_W-1:0]  exp_a;
  logic [MS_W-1:0]    stmo_a;
  logic [MS_W-1:0]    sper_a;
  logic [MS_W-1:0]    add_op;
  logic [TIME_W-1:0]  sum;
  logic               out_free;

  // one slot read port shared by command execution and the scan
  assign addr    = ctl_i.exec ? SLOT_W'(slot_r) : ctl_i.scan_idx;
  assign slot_ok = (32'(slot_r) < 32'(SLOTS));
  assign exp_a   = expiry_r[addr];
  assign stmo_a  = stmo_r[addr];
  assign sper_a  = sper_r[addr];

  // adder operand: timeout for start and reset, period otherwise
  always_comb begin
    add_op = sper_a;
    if (ctl_i.exec) begin
      case (cmd_r)
        CMD_START: add_op = tmo_r;
        CMD_RESET: add_op = (tmo_r != '0) ? tmo_r : stmo_a;
        default:   add_op = sper_a;
      endcase
    end
  end

  assign sum      = now_r + TIME_W'(add_op);
  assign out_free = !out_v_r || out_ready;

  assign stat_o.is_tick  = (cmd_r == CMD_TICK);
  assign stat_o.expired  = in_use_r[addr] && !held_r[addr] && (now_r >= exp_a);
  assign stat_o.pend_v   = pend_v_r;
  assign stat_o.out_free = out_free;

  assign out_valid  = out_v_r;
  assign fired_slot = out_slot_r;
  assign last_fired = out_last_r;

  // input latch and slot payload
  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      cmd_r  <= cmd_i;
      slot_r <= slot_i;
      tmo_r  <= timeout_i;
      per_r  <= period_i;
    end
    if (ctl_i.exec && slot_ok) begin
      case (cmd_r)
        CMD_START: begin
          stmo_r[addr]   <= tmo_r;
          sper_r[addr]   <= per_r;
          expiry_r[addr] <= sum;
        end
        CMD_RESET: begin
          if (in_use_r[addr]) begin
            expiry_r[addr] <= sum;
            if (per_r != '0) begin
              sper_r[addr] <= per_r;
            end
          end
        end
        CMD_RESUME: begin
          if (in_use_r[addr] && sper_a != '0) begin
            expiry_r[addr] <= sum;
          end
        end
        default: ;
      endcase
    end
    // periodic reload on fire
    if (ctl_i.fire && sper_a != '0) begin
      expiry_r[addr] <= sum;
    end
    if (ctl_i.fire) begin
      pend_slot_r <= SLOTF_W'(addr);
    end
    // the output register only loads when a held fire moves into it
    if ((ctl_i.fire && pend_v_r) || ctl_i.flush) begin
      out_slot_r <= pend_slot_r;
      out_last_r <= ctl_i.flush;
    end
  end

  // control state: time, slot flags, result valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      in_use_r <= '0;
      held_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (ctl_i.tick_inc) begin
        now_r <= now_r + 1'b1;
      end
      if (ctl_i.exec && slot_ok) begin
        case (cmd_r)
          CMD_START: begin
            in_use_r[addr] <= 1'b1;
            held_r[addr]   <= 1'b0;
          end
          CMD_SUSPEND: begin
            if (in_use_r[addr]) begin
              held_r[addr] <= 1'b1;
            end
          end
          CMD_RESUME: begin
            if (in_use_r[addr]) begin
              held_r[addr] <= 1'b0;
            end
          end
          CMD_STOP: begin
            in_use_r[addr] <= 1'b0;
            held_r[addr]   <= 1'b0;
          end
          default: ;
        endcase
      end
      // one-shot slots free themselves when they fire
      if (ctl_i.fire && sper_a == '0) begin
        in_use_r[addr] <= 1'b0;
        held_r[addr]   <= 1'b0;
      end
      if (ctl_i.fire) begin
        pend_v_r <= 1'b1;
      end else if (ctl_i.flush) begin
        pend_v_r <= 1'b0;
      end
      if ((ctl_i.fire && pend_v_r) || ctl_i.flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/multi_timer_bank.sv @@
// multi_timer_bank: top level of the command-driven timer bank.
// Depends on mtb_pkg, mtb_ctrl and mtb_dpath.
//
// Usage
//   Input channel: one command per transfer. in_tuser carries the command
//   (tick, start, reset, suspend, resume, stop); in_tdata carries the slot,
//   the timeout and the period in ms.
//   Output channel: one transfer per expired slot on a tick; out_tdata holds
//   the slot number, out_tlast marks the last fire of that tick.
//   Sequencing: a slot command is latched and then executed before in_tready
//   returns. A tick is latched, then advances the counter, then scans the
//   slots in order through the single slot read port and 64-bit adder, and
//   then pushes the final fire.
//   A fire is held back and reaches the output only when the next fire is
//   found or the scan ends, since last marking needs to know which is last.
//   Receiver stall: the scan halts on an expired slot while a fire is held
//   and the output register holds a transfer not yet taken; nothing is
//   dropped.
//   Reset: clears the time counter and frees every slot; no output pending.
`default_nettype none

module multi_timer_bank (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mtb_pkg::IN_TDATA_W-1:0]  in_tdata,  // slot, timeout_ms, period_ms
  input  wire logic [mtb_pkg::CMD_W-1:0]       in_tuser,  // command
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mtb_pkg::OUT_TDATA_W-1:0]      out_tdata, // fired_slot, zero pad
  output logic                                 out_tlast  // last_fired
);
  import mtb_pkg::*;

  mtb_ctl_t           ctl;
  mtb_stat_t          stat;
  logic [SLOTF_W-1:0] fired_slot;

  // sequencer
  mtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  // storage and arithmetic
  mtb_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .cmd_i      (in_tuser),
    .slot_i     (in_tdata[SLOTF_W-1:0]),
    .timeout_i  (in_tdata[SLOTF_W+MS_W-1:SLOTF_W]),
    .period_i   (in_tdata[SLOTF_W+2*MS_W-1:SLOTF_W+MS_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .fired_slot (fired_slot),
    .last_fired (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'(fired_slot);

endmodule

`default_nettype wire

@@ rtl/core/mtb_checker.sv @@
// mtb_checker: port-level assertions for the timer bank, bound to the top.
// Depends on mtb_pkg and multi_timer_bank.
`default_nettype none

module mtb_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [mtb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);
  import mtb_pkg::*;

  // a stalled result holds valid, slot and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // no result is pending after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the bank works on one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");

  // slot numbers fit the slot field, the pad stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:SLOTF_W] == '0)
    else $error("result padding not zero");

endmodule

bind multi_timer_bank mtb_checker u_mtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
